// ===== rtl/pflp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pflp_pkg: shared types, constants and helpers
// Fixed-point constants, register map, pipeline stage map and Q8.24 helpers.
// ----------------------------------------------------------------------------
package pflp_pkg;

   // Q8.24 constants: 0.004 and 0.1
   localparam logic signed [31:0] K_FLOAT = 32'sd67109;
   localparam logic signed [31:0] K_DRAG  = 32'sd1677722;

   localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] S32_MIN = 32'sh80000000;

   // register reset values
   localparam logic [31:0] RST_COUPLING = 32'd167772;
   localparam logic [31:0] RST_FIELD    = 32'd16777216;
   localparam logic [30:0] RST_DT       = 31'd167772;

   // register map, index = byte address / 4
   typedef enum logic [2:0] {
      REG_COUPLING = 3'd0,
      REG_FIELD_X  = 3'd1,
      REG_FIELD_Y  = 3'd2,
      REG_FIELD_Z  = 3'd3,
      REG_DT       = 3'd4
   } reg_idx_type;

   // particle kinds and charge codes
   localparam logic [1:0] KIND_FLOAT = 2'd1;
   localparam logic [1:0] KIND_DRAG  = 2'd2;
   localparam logic [1:0] CHG_POS    = 2'b01;
   localparam logic [1:0] CHG_NEG    = 2'b11;
   localparam logic [1:0] CHG_NEG2   = 2'b10;

   // divider: quotient bits per stage and stage count
   localparam int DIV_BITS   = 4;
   localparam int DIV_STAGES = 32 / DIV_BITS;

   // pipeline stage map
   localparam int S_IN    = 1;
   localparam int S_PROD  = 2;
   localparam int S_CROSS = 3;
   localparam int S_CPROD = 4;
   localparam int S_FORCE = 5;
   localparam int S_DPREP = 6;
   localparam int S_ACC   = S_DPREP + DIV_STAGES + 1;
   localparam int S_APROD = S_ACC + 1;
   localparam int S_HALF  = S_APROD + 1;
   localparam int S_VPROD = S_HALF + 1;
   localparam int S_OUT   = S_VPROD + 1;

   typedef struct packed {
      logic [1:0]       particle_kind;
      logic [2:0][31:0] position;
      logic [2:0][31:0] velocity;
      logic [30:0]      particle_mass;
      logic [1:0]       particle_charge;
      logic [2:0]       fixed_axes;
      logic             boost_z;
   } item_type;

   // clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'(S32_MAX)) begin
         r = S32_MAX;
      end else if (v < 64'(S32_MIN)) begin
         r = S32_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // divide by 2^sh, rounding toward zero
   function automatic logic signed [63:0] trunc_shift(input logic signed [63:0] v,
                                                      input int unsigned sh);
      logic signed [63:0] bias;
      bias = v[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
      return (v + bias) >>> sh;
   endfunction

endpackage

// ===== rtl/particle_force_and_leapfrog_push.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_force_and_leapfrog_push
// Charged particle force and velocity-Verlet push, one particle per word.
// ----------------------------------------------------------------------------
// One particle word enters per clock and one result word leaves per clock.
// The line has 19 register stages, and rsp_tvalid is the valid bit of the
// last one. The pipeline forms the cross product force, adds float and
// drag terms, divides by mass in a radix-2 restoring divider spread over 8
// stages of 4 quotient bits, then runs the half-kick, drift and half-kick.
// All stages advance together; they hold only while a finished result waits
// on rsp_tready, and bubbles inside the line are not squeezed out during a
// hold. Registers sit on an APB-style port at 4*index and must only be
// written while the pipeline is empty.
module particle_force_and_leapfrog_push (
   input  logic         clock,
   input  logic         reset,
   // input words
   input  logic         req_tvalid,
   output logic         req_tready,
   // position_x, _y, _z, velocity_x, _y, _z, particle_mass(31),
   // particle_charge(2), fixed_axes(3), boost_z(1), zero pad(3)
   input  logic [231:0] req_tdata,
   // particle_kind
   input  logic [1:0]   req_tuser,
   // result words
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_position_x, _y, _z, new_velocity_x, _y, _z, force_out_x, _y, _z
   output logic [287:0] rsp_tdata,
   // configuration
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   // configuration registers
   logic signed [31:0] coupling_ff;
   logic [2:0][31:0]   field_ff;
   logic [30:0]        dt_ff;

   // valid line and global advance
   logic               vld_ff [pflp_pkg::S_IN:pflp_pkg::S_OUT];
   logic               adv;

   // item line and force line
   pflp_pkg::item_type item_ff [pflp_pkg::S_IN:pflp_pkg::S_VPROD];
   logic [2:0][31:0]   force_ff [pflp_pkg::S_FORCE:pflp_pkg::S_OUT];
   logic [2:0][31:0]   force_in;

   // stage registers
   logic signed [63:0] pa_ff [3], pb_ff [3], pa_in [3], pb_in [3];
   logic signed [63:0] dmp_ff, dmp_in, flp_ff, flp_in;
   logic signed [31:0] cross_ff [3], cross_in [3];
   logic signed [31:0] dm_ff, dm_in, ezf3_ff, ezf3_in, ezf4_ff;
   logic signed [63:0] cp_ff [3], cp_in [3], dp_ff [3], dp_in [3];
   logic [30:0]        rem_ff [pflp_pkg::DIV_STAGES+1][3];
   logic [30:0]        rem_in [pflp_pkg::DIV_STAGES+1][3];
   logic [31:0]        nlow_ff [pflp_pkg::DIV_STAGES+1][3];
   logic [31:0]        nlow_in [pflp_pkg::DIV_STAGES+1][3];
   logic [31:0]        quot_ff [pflp_pkg::DIV_STAGES+1][3];
   logic [31:0]        quot_in [pflp_pkg::DIV_STAGES+1][3];
   logic [2:0]         neg_ff [pflp_pkg::DIV_STAGES+1];
   logic [2:0]         ovf_ff [pflp_pkg::DIV_STAGES+1];
   logic [2:0]         neg_in [pflp_pkg::DIV_STAGES+1];
   logic [2:0]         ovf_in [pflp_pkg::DIV_STAGES+1];
   logic signed [31:0] acc_ff [3], acc_in [3];
   logic signed [63:0] ap_ff [3], ap_in [3];
   logic signed [39:0] dv_ff [3], dv_in [3];
   logic signed [31:0] vh_ff [3], vh_in [3];
   logic signed [63:0] vp_ff [3], vp_in [3];
   logic signed [31:0] nv_ff [3], nv_in [3];
   logic signed [31:0] nvo_ff [3];
   logic signed [31:0] np_ff [3], np_in [3];

   logic               cfg_wr;

   // ---------------------------------------------------------------- config
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         coupling_ff <= pflp_pkg::RST_COUPLING;
         field_ff    <= {3{pflp_pkg::RST_FIELD}};
         dt_ff       <= pflp_pkg::RST_DT;
      end else if (cfg_wr) begin
         case (pflp_pkg::reg_idx_type'(csr_paddr[4:2]))
            pflp_pkg::REG_COUPLING: coupling_ff <= csr_pwdata;
            pflp_pkg::REG_FIELD_X:  field_ff[0] <= csr_pwdata;
            pflp_pkg::REG_FIELD_Y:  field_ff[1] <= csr_pwdata;
            pflp_pkg::REG_FIELD_Z:  field_ff[2] <= csr_pwdata;
            pflp_pkg::REG_DT:       dt_ff       <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (pflp_pkg::reg_idx_type'(csr_paddr[4:2]))
         pflp_pkg::REG_COUPLING: csr_prdata = coupling_ff;
         pflp_pkg::REG_FIELD_X:  csr_prdata = field_ff[0];
         pflp_pkg::REG_FIELD_Y:  csr_prdata = field_ff[1];
         pflp_pkg::REG_FIELD_Z:  csr_prdata = field_ff[2];
         pflp_pkg::REG_DT:       csr_prdata = {1'b0, dt_ff};
         default:                csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------ flow control
   // Hold every stage only while the output word is waiting.
   assign adv        = !(vld_ff[pflp_pkg::S_OUT] && !rsp_tready);
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = pflp_pkg::S_IN; k <= pflp_pkg::S_OUT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[pflp_pkg::S_IN] <= req_tvalid;
         for (int k = pflp_pkg::S_IN + 1; k <= pflp_pkg::S_OUT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------ arithmetic
   always_comb begin
      logic [2:0][31:0]   v;
      logic signed [63:0] t, chg, extra;
      logic [31:0]        mag;
      logic [31:0]        r2;
      logic [30:0]        r;
      logic [31:0]        n, q;
      logic [30:0]        m;
      logic signed [31:0] a;

      // products of velocity and field
      v        = item_ff[pflp_pkg::S_IN].velocity;
      pa_in[0] = $signed(v[1]) * $signed(field_ff[2]);
      pb_in[0] = $signed(v[2]) * $signed(field_ff[1]);
      pa_in[1] = $signed(v[2]) * $signed(field_ff[0]);
      pb_in[1] = $signed(v[0]) * $signed(field_ff[2]);
      pa_in[2] = $signed(v[0]) * $signed(field_ff[1]);
      pb_in[2] = $signed(v[1]) * $signed(field_ff[0]);
      dmp_in   = pflp_pkg::K_DRAG * $signed({1'b0, item_ff[pflp_pkg::S_IN].particle_mass});
      flp_in   = pflp_pkg::K_FLOAT * $signed(item_ff[pflp_pkg::S_IN].position[2]);

      // cross product, drag and float coefficients
      for (int i = 0; i < 3; i++) begin
         cross_in[i] = pflp_pkg::sat32(pflp_pkg::trunc_shift(pa_ff[i], 24)
                                       - pflp_pkg::trunc_shift(pb_ff[i], 24));
      end
      dm_in   = 32'(dmp_ff >>> 24);
      ezf3_in = 32'(-pflp_pkg::trunc_shift(flp_ff, 24));

      // coupling and drag products
      for (int i = 0; i < 3; i++) begin
         cp_in[i] = coupling_ff * cross_ff[i];
         dp_in[i] = dm_ff * $signed(item_ff[pflp_pkg::S_CROSS].velocity[i]);
      end

      // force per axis
      for (int i = 0; i < 3; i++) begin
         t = pflp_pkg::trunc_shift(cp_ff[i], 24);
         case (item_ff[pflp_pkg::S_CPROD].particle_charge)
            pflp_pkg::CHG_POS:  chg = t;
            pflp_pkg::CHG_NEG:  chg = -t;
            pflp_pkg::CHG_NEG2: chg = -(t <<< 1);
            default:            chg = 64'sd0;
         endcase
         extra = 64'sd0;
         if (item_ff[pflp_pkg::S_CPROD].particle_kind == pflp_pkg::KIND_DRAG) begin
            extra = -pflp_pkg::trunc_shift(dp_ff[i], 24);
         end else if (item_ff[pflp_pkg::S_CPROD].particle_kind == pflp_pkg::KIND_FLOAT
                      && i == 2) begin
            extra = 64'(ezf4_ff);
         end
         force_in[i] = item_ff[pflp_pkg::S_CPROD].fixed_axes[i] ? 32'd0
                       : pflp_pkg::sat32(chg + extra);
      end

      // divider setup: |force| * 2^24 / mass, overflow when quotient >= 2^32
      m = item_ff[pflp_pkg::S_FORCE].particle_mass;
      for (int i = 0; i < 3; i++) begin
         neg_in[0][i]  = force_ff[pflp_pkg::S_FORCE][i][31];
         mag           = neg_in[0][i] ? 32'(-force_ff[pflp_pkg::S_FORCE][i])
                                      : force_ff[pflp_pkg::S_FORCE][i];
         ovf_in[0][i]  = {7'd0, mag[31:8]} >= m;
         rem_in[0][i]  = {7'd0, mag[31:8]};
         nlow_in[0][i] = {mag[7:0], 24'd0};
         quot_in[0][i] = '0;
      end

      // restoring divider, DIV_BITS quotient bits per stage
      for (int k = 0; k < pflp_pkg::DIV_STAGES; k++) begin
         m = item_ff[pflp_pkg::S_DPREP + k].particle_mass;
         for (int i = 0; i < 3; i++) begin
            r = rem_ff[k][i];
            n = nlow_ff[k][i];
            q = quot_ff[k][i];
            for (int b = 0; b < pflp_pkg::DIV_BITS; b++) begin
               r2 = {r, n[31]};
               n  = {n[30:0], 1'b0};
               if (r2 >= {1'b0, m}) begin
                  q = {q[30:0], 1'b1};
                  r = 31'(r2 - {1'b0, m});
               end else begin
                  q = {q[30:0], 1'b0};
                  r = r2[30:0];
               end
            end
            rem_in[k+1][i]  = r;
            nlow_in[k+1][i] = n;
            quot_in[k+1][i] = q;
         end
         neg_in[k+1] = neg_ff[k];
         ovf_in[k+1] = ovf_ff[k];
      end

      // acceleration: sign, saturate, zero mass, z boost
      for (int i = 0; i < 3; i++) begin
         q = quot_ff[pflp_pkg::DIV_STAGES][i];
         if (item_ff[pflp_pkg::S_ACC-1].particle_mass == '0) begin
            a = 32'sd0;
         end else if (ovf_ff[pflp_pkg::DIV_STAGES][i]) begin
            a = neg_ff[pflp_pkg::DIV_STAGES][i] ? pflp_pkg::S32_MIN : pflp_pkg::S32_MAX;
         end else if (!neg_ff[pflp_pkg::DIV_STAGES][i]) begin
            a = q[31] ? pflp_pkg::S32_MAX : $signed(q);
         end else begin
            a = (q > 32'h80000000) ? pflp_pkg::S32_MIN : $signed(-q);
         end
         if (i == 2 && item_ff[pflp_pkg::S_ACC-1].boost_z) begin
            a = pflp_pkg::sat32(64'(a) <<< 1);
         end
         acc_in[i] = a;
      end

      // kick, drift, kick
      for (int i = 0; i < 3; i++) begin
         ap_in[i] = acc_ff[i] * $signed({1'b0, dt_ff});
         dv_in[i] = 40'(pflp_pkg::trunc_shift(ap_ff[i], 25));
         vh_in[i] = pflp_pkg::sat32(64'($signed(item_ff[pflp_pkg::S_APROD].velocity[i]))
                                    + 64'(dv_in[i]));
         vp_in[i] = vh_ff[i] * $signed({1'b0, dt_ff});
         nv_in[i] = pflp_pkg::sat32(64'(vh_ff[i]) + 64'(dv_ff[i]));
         np_in[i] = pflp_pkg::sat32(64'($signed(item_ff[pflp_pkg::S_VPROD].position[i]))
                                    + pflp_pkg::trunc_shift(vp_ff[i], 24));
      end
   end

   // ------------------------------------------------------- pipeline payload
   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff[pflp_pkg::S_IN] <= '{
            particle_kind:   req_tuser,
            position:        req_tdata[95:0],
            velocity:        req_tdata[191:96],
            particle_mass:   req_tdata[222:192],
            particle_charge: req_tdata[224:223],
            fixed_axes:      req_tdata[227:225],
            boost_z:         req_tdata[228]
         };
         for (int k = pflp_pkg::S_IN + 1; k <= pflp_pkg::S_VPROD; k++) begin
            item_ff[k] <= item_ff[k-1];
         end
         force_ff[pflp_pkg::S_FORCE] <= force_in;
         for (int k = pflp_pkg::S_FORCE + 1; k <= pflp_pkg::S_OUT; k++) begin
            force_ff[k] <= force_ff[k-1];
         end
         for (int i = 0; i < 3; i++) begin
            pa_ff[i]    <= pa_in[i];
            pb_ff[i]    <= pb_in[i];
            cross_ff[i] <= cross_in[i];
            cp_ff[i]    <= cp_in[i];
            dp_ff[i]    <= dp_in[i];
            acc_ff[i]   <= acc_in[i];
            ap_ff[i]    <= ap_in[i];
            dv_ff[i]    <= dv_in[i];
            vh_ff[i]    <= vh_in[i];
            vp_ff[i]    <= vp_in[i];
            nv_ff[i]    <= nv_in[i];
            nvo_ff[i]   <= nv_ff[i];
            np_ff[i]    <= np_in[i];
         end
         dmp_ff  <= dmp_in;
         flp_ff  <= flp_in;
         dm_ff   <= dm_in;
         ezf3_ff <= ezf3_in;
         ezf4_ff <= ezf3_ff;
         for (int k = 0; k <= pflp_pkg::DIV_STAGES; k++) begin
            rem_ff[k]  <= rem_in[k];
            nlow_ff[k] <= nlow_in[k];
            quot_ff[k] <= quot_in[k];
            neg_ff[k]  <= neg_in[k];
            ovf_ff[k]  <= ovf_in[k];
         end
      end
   end

   // ----------------------------------------------------------------- output
   assign rsp_tvalid = vld_ff[pflp_pkg::S_OUT];
   assign rsp_tdata  = {force_ff[pflp_pkg::S_OUT],
                        nvo_ff[2], nvo_ff[1], nvo_ff[0],
                        np_ff[2], np_ff[1], np_ff[0]};

endmodule

// ===== tb/particle_force_and_leapfrog_push_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_force_and_leapfrog_push_checker
// Watches the particle, result and register ports, predicts each result word
// from its own fixed-point model of the push and compares it field by field.
// ----------------------------------------------------------------------------
module particle_force_and_leapfrog_push_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [231:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [287:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           error_count,
   output int           pending_count,
   output int           result_count
);

   localparam longint Q_ONE = 64'sd16777216;
   localparam longint LIM_HI = 64'sd2147483647;
   localparam longint LIM_LO = -64'sd2147483648;

   longint         eps_q, field_q[3], dt_q;
   logic [287:0]   push_result_q[$];
   string          field_names[9] = '{"new_position_x", "new_position_y", "new_position_z",
                                      "new_velocity_x", "new_velocity_y", "new_velocity_z",
                                      "force_out_x", "force_out_y", "force_out_z"};

   function automatic longint clamp_q(longint v);
      if (v > LIM_HI) return LIM_HI;
      if (v < LIM_LO) return LIM_LO;
      return v;
   endfunction

   function automatic longint qprod(longint a, longint b);
      return (a * b) / Q_ONE;
   endfunction

   function automatic longint free_axis_force(bit held, longint chg, longint va, longint fb,
                                              longint vb, longint fa, longint extra);
      longint cr;
      if (held) return 0;
      cr = clamp_q(qprod(va, fb) - qprod(vb, fa));
      return clamp_q(chg * qprod(eps_q, cr) + extra);
   endfunction

   // one particle word in, one packed result word out
   function automatic logic [287:0] push_particle(logic [231:0] d, logic [1:0] kind);
      longint pos[3], vel[3], f[3], ext[3], mass, chg, acc, dv, vh, dm;
      logic [2:0] held;
      logic [287:0] r;
      for (int i = 0; i < 3; i++) begin
         pos[i] = longint'($signed(d[32*i +: 32]));
         vel[i] = longint'($signed(d[96 + 32*i +: 32]));
         ext[i] = 0;
      end
      mass = longint'(d[222:192]);
      chg  = longint'($signed(d[224:223]));
      held = d[227:225];
      if (kind == pflp_pkg::KIND_FLOAT) begin
         ext[2] = -qprod(longint'(pflp_pkg::K_FLOAT), pos[2]);
      end else if (kind == pflp_pkg::KIND_DRAG) begin
         dm = qprod(longint'(pflp_pkg::K_DRAG), mass);
         for (int i = 0; i < 3; i++) ext[i] = -qprod(dm, vel[i]);
      end
      f[0] = free_axis_force(held[0], chg, vel[1], field_q[2], vel[2], field_q[1], ext[0]);
      f[1] = free_axis_force(held[1], chg, vel[2], field_q[0], vel[0], field_q[2], ext[1]);
      f[2] = free_axis_force(held[2], chg, vel[0], field_q[1], vel[1], field_q[0], ext[2]);
      for (int i = 0; i < 3; i++) begin
         acc = (mass != 0) ? clamp_q((f[i] * Q_ONE) / mass) : 0;
         if (i == 2 && d[228]) acc = clamp_q(2 * acc);
         dv = qprod(acc, dt_q) / 2;
         vh = clamp_q(vel[i] + dv);
         r[32*i +: 32]      = 32'(clamp_q(pos[i] + qprod(vh, dt_q)));
         r[96 + 32*i +: 32] = 32'(clamp_q(vh + dv));
         r[192 + 32*i +: 32] = 32'(f[i]);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what);
      if (error_count < 30) $display("MISMATCH @%0t: %s", $realtime, what);
      error_count++;
   endtask

   assign pending_count = push_result_q.size();

   always @(posedge clock) begin
      logic [287:0] want;
      if (reset) begin
         eps_q    = longint'($signed(pflp_pkg::RST_COUPLING));
         field_q  = '{longint'($signed(pflp_pkg::RST_FIELD)),
                      longint'($signed(pflp_pkg::RST_FIELD)),
                      longint'($signed(pflp_pkg::RST_FIELD))};
         dt_q     = longint'(pflp_pkg::RST_DT);
         push_result_q.delete();
      end else begin
         // register writes land at the access phase edge
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (pflp_pkg::reg_idx_type'(csr_paddr[4:2]))
               pflp_pkg::REG_COUPLING: eps_q = longint'($signed(csr_pwdata));
               pflp_pkg::REG_FIELD_X:  field_q[0] = longint'($signed(csr_pwdata));
               pflp_pkg::REG_FIELD_Y:  field_q[1] = longint'($signed(csr_pwdata));
               pflp_pkg::REG_FIELD_Z:  field_q[2] = longint'($signed(csr_pwdata));
               pflp_pkg::REG_DT:       dt_q = longint'(csr_pwdata[30:0]);
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (push_result_q.size() == 0) begin
               report_mismatch("result word with nothing expected");
            end else begin
               want = push_result_q.pop_front();
               for (int i = 0; i < 9; i++)
                  if (rsp_tdata[32*i +: 32] !== want[32*i +: 32])
                     report_mismatch($sformatf("%s got %h want %h", field_names[i],
                                               rsp_tdata[32*i +: 32], want[32*i +: 32]));
            end
         end
         if (req_tvalid && req_tready) push_result_q.push_back(push_particle(req_tdata, req_tuser));
      end
   end

endmodule

// ===== tb/particle_force_and_leapfrog_push_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_force_and_leapfrog_push_tb
// Drives particle words in bursts through several register settings while the
// result side stalls on its own pattern; the checker predicts and compares.
// ----------------------------------------------------------------------------
module particle_force_and_leapfrog_push_tb;

   localparam int PIPE_DEPTH = 19;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [231:0] req_tdata = '0;   // pos x,y,z, vel x,y,z, mass, charge, fixed, boost
   logic [1:0]   req_tuser = '0;   // particle_kind
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [287:0] rsp_tdata;        // new pos x,y,z, new vel x,y,z, force x,y,z
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [4:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   int           error_count, pending_count, result_count;
   int           sent_count = 0;
   int           setting_count = 0;
   bit           long_hold_req = 1'b0;

   always #10 clock = ~clock;

   particle_force_and_leapfrog_push u_top (.*);

   particle_force_and_leapfrog_push_checker u_check (.*);

   // Receiver: repeatedly pick a random stall pattern; a long hold-off on request.
   initial begin
      int mode;
      forever begin
         mode = $urandom_range(0, 3);
         for (int i = 0; i < 64; i++) begin
            @(negedge clock);
            if (long_hold_req) begin
               // hold off long enough for the pipeline to back up into the input
               long_hold_req = 1'b0;
               rsp_tready <= 1'b0;
               repeat (400) @(negedge clock);
               rsp_tready <= 1'b1;
            end else begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= ($urandom_range(0, 1) == 1);
                  2: rsp_tready <= ($urandom_range(0, 3) == 0);
                  default: rsp_tready <= ($urandom_range(0, 7) != 0);
               endcase
            end
         end
      end
   end

   // Build one particle word. Tame values keep the push out of saturation.
   task automatic make_particle(input bit wild, output logic [231:0] d, output logic [1:0] kind);
      d = '0;
      for (int i = 0; i < 6; i++)
         d[32*i +: 32] = wild ? $urandom : 32'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
      d[222:192] = wild ? 31'($urandom) : 31'($urandom_range(32'h0040_0000, 32'h0400_0000));
      d[224:223] = wild ? 2'($urandom_range(0, 3))
                        : (($urandom_range(0, 1) == 1) ? pflp_pkg::CHG_POS : pflp_pkg::CHG_NEG);
      d[227:225] = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'b000;
      d[228]     = $urandom_range(0, 1);
      kind       = 2'($urandom_range(0, wild ? 3 : 2));
   endtask

   // Offer one word and hold it until accepted.
   task automatic send_particle(input logic [231:0] d, input logic [1:0] kind);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Drain every expected word, then let the pipeline go quiet.
   task automatic drain;
      idle_sender(1);
      while (pending_count != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 5) @(negedge clock);
   endtask

   task automatic write_reg(input pflp_pkg::reg_idx_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic load_setting(input logic [31:0] eps, input logic [31:0] fx,
                               input logic [31:0] fy, input logic [31:0] fz,
                               input logic [31:0] dt);
      write_reg(pflp_pkg::REG_COUPLING, eps);
      write_reg(pflp_pkg::REG_FIELD_X, fx);
      write_reg(pflp_pkg::REG_FIELD_Y, fy);
      write_reg(pflp_pkg::REG_FIELD_Z, fz);
      write_reg(pflp_pkg::REG_DT, dt);
      setting_count++;
   endtask

   // Random burst traffic; gaps of random length between bursts unless no_gaps is set.
   task automatic random_traffic(input int count, input int wild_pct, input bit no_gaps);
      logic [231:0] d;
      logic [1:0]   kind;
      int           burst;
      burst = $urandom_range(1, 16);
      for (int n = 0; n < count; n++) begin
         make_particle($urandom_range(0, 99) < wild_pct, d, kind);
         send_particle(d, kind);
         if (--burst == 0) begin
            burst = $urandom_range(1, 16);
            if (!no_gaps) idle_sender($urandom_range(0, 6));
         end
      end
   endtask

   initial begin
      logic [231:0] d;
      logic [1:0]   kind;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset registers, field and flag extremes, odd codes.
      for (int n = 0; n < 22; n++) begin
         make_particle(1'b0, d, kind);
         case (n)
            0: d[191:0] = '0;
            1: for (int i = 0; i < 6; i++) d[32*i +: 32] = 32'h7fff_ffff;
            2: for (int i = 0; i < 6; i++) d[32*i +: 32] = 32'h8000_0000;
            3: d[222:192] = 31'h7fff_ffff;
            4: d[222:192] = 31'd1;
            5: d[222:192] = 31'd0;                 // zero mass: no acceleration
            6: d[224:223] = pflp_pkg::CHG_NEG2;    // charge pattern reads as -2
            7: d[224:223] = 2'b00;
            8: kind = 2'd3;                        // unused kind acts as normal
            9: kind = pflp_pkg::KIND_FLOAT;
            10: begin   // fixed z drops float term
               kind = pflp_pkg::KIND_FLOAT;
               d[227:225] = 3'b100;
            end
            11: kind = pflp_pkg::KIND_DRAG;
            12: begin kind = pflp_pkg::KIND_DRAG; d[227:225] = 3'b111; end
            13: begin d[228] = 1'b1; d[227:225] = 3'b000; end
            14: begin d[228] = 1'b1; d[222:192] = 31'd1; d[191:96] = {3{32'h7fff_ffff}}; end
            15: begin d[222:192] = 31'd1; d[224:223] = pflp_pkg::CHG_NEG; end  // clamps
            16: begin
               kind = pflp_pkg::KIND_DRAG;
               d[222:192] = 31'h7fff_ffff;
               d[191:96] = {3{32'h8000_0000}};
            end
            17: begin kind = pflp_pkg::KIND_FLOAT; d[95:64] = 32'h8000_0000; end
            18: d[227:225] = 3'b001;
            19: d[227:225] = 3'b010;
            default: ;
         endcase
         send_particle(d, kind);
      end
      drain;

      // Random traffic under a series of register settings, extremes included.
      load_setting(32'd167772, 32'h0100_0000, 32'hff00_0000, 32'h0080_0000, 32'd167772);
      random_traffic(170, 10, 1'b0);
      drain;
      load_setting(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'h7fff_ffff);
      random_traffic(120, 40, 1'b0);
      drain;
      load_setting(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'd0);
      random_traffic(120, 40, 1'b0);
      drain;

      // Back up the pipeline: long receiver hold-off with a steady sender.
      load_setting(32'h0400_0000, 32'h0200_0000, 32'h0040_0000, 32'hfe00_0000, 32'h0100_0000);
      long_hold_req = 1'b1;
      random_traffic(200, 15, 1'b1);
      drain;

      for (int p = 0; p < 3; p++) begin
         load_setting($urandom, $urandom, $urandom, $urandom, {1'b0, 31'($urandom)});
         random_traffic(60, 50, 1'b0);
         drain;
      end
      load_setting(32'd1677722, $urandom_range(0, 32'h0400_0000) - 32'h0200_0000,
                   $urandom_range(0, 32'h0400_0000) - 32'h0200_0000, 32'h0100_0000,
                   32'($urandom_range(1, 32'h0200_0000)));
      random_traffic(200, 10, 1'b0);
      drain;

      $display("Run covered %0d particle words across %0d register settings; %0d results checked.",
               sent_count, setting_count, result_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legitimate run.
   initial begin
      #20ms;
      $display("Timeout: %0d words still outstanding", pending_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
